/* src/hcl_pkg.sv */
package hcl_pkg;

    typedef enum logic [9:0] {
        G_IDLE  = 10'b0000000001,
        G_ERROR = 10'b0000000010,
        G_CHAN  = 10'b0000000100,
        G_DEL   = 10'b0000001000,
        G_SENSE = 10'b0000010000,
        G_BOOST = 10'b0000100000,
        G_ONOFF = 10'b0001000000,
        G_AT    = 10'b0010000000,
        G_TIME  = 10'b0100000000,
        G_DONE  = 10'b1000000000
    } gst_t;

    typedef enum logic [3:0] {
        TK_NONE, TK_CHAN, TK_SENSE, TK_BOOST, TK_BOOST_TIME, TK_ON, TK_OFF,
        TK_NOW, TK_AT, TK_PEG, TK_DAY, TK_DEL, TK_OTHER
    } tk_t;

    typedef enum logic [2:0] {
        CMD_NONE, CMD_ON, CMD_OFF, CMD_DEL, CMD_HEAT_BURST
    } cmd_t;

    typedef struct packed {
        cmd_t        kind;
        logic [1:0]  chan;
        logic [7:0]  sense;
        logic        tv;
        logic [10:0] minutes;
        logic        dv;
        logic [3:0]  day;
    } held_t;

    localparam logic [1:0] KIND_NOW   = 2'd0;
    localparam logic [1:0] KIND_AT    = 2'd1;
    localparam logic [1:0] KIND_BOOST = 2'd2;
    localparam logic [1:0] KIND_DEL   = 2'd3;

    localparam int FL_CHAN     = 0;
    localparam int FL_SENSE    = 1;
    localparam int FL_NUM      = 2;
    localparam int FL_NUM_OVER = 3;
    localparam int FL_TIME     = 4;
    localparam int FL_KW       = 5;
    localparam int FL_CV       = 13;
    localparam int FL_DIG      = 15;
    localparam logic [15:0] FL_RESET = 16'h1FF7;

    localparam int NUM_KW   = 8;
    localparam int NUM_DAYS = 9;

    localparam logic [7:0] KW_TXT [NUM_KW][5] = '{
        '{"b", "o", "o", "s", "t"},
        '{"o", "n", 8'h00, 8'h00, 8'h00},
        '{"o", "f", "f", 8'h00, 8'h00},
        '{"n", "o", "w", 8'h00, 8'h00},
        '{"d", "e", "l", 8'h00, 8'h00},
        '{"c", "l", "e", "a", "r"},
        '{"a", "t", 8'h00, 8'h00, 8'h00},
        '{"/", "/", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd5, 4'd2, 4'd3, 4'd3, 4'd3, 4'd5, 4'd2, 4'd2};
    localparam tk_t KW_TOK [NUM_KW] = '{TK_BOOST, TK_ON, TK_OFF, TK_NOW, TK_DEL, TK_DEL,
                                        TK_AT, TK_NONE};

    localparam logic [7:0] DAY_TXT [NUM_DAYS][9] = '{
        '{"t", "o", "d", "a", "y", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "u", "n", "d", "a", "y", 8'h00, 8'h00, 8'h00},
        '{"m", "o", "n", "d", "a", "y", 8'h00, 8'h00, 8'h00},
        '{"t", "u", "e", "s", "d", "a", "y", 8'h00, 8'h00},
        '{"w", "e", "d", "n", "e", "s", "d", "a", "y"},
        '{"t", "h", "u", "r", "s", "d", "a", "y", 8'h00},
        '{"f", "r", "i", "d", "a", "y", 8'h00, 8'h00, 8'h00},
        '{"s", "a", "t", "u", "r", "d", "a", "y", 8'h00},
        '{"a", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] DAY_LEN [NUM_DAYS] = '{4'd5, 4'd6, 4'd6, 4'd7, 4'd9, 4'd8, 4'd6,
                                                  4'd8, 4'd3};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

/* src/heating_command_line_parser.sv */
// Channel | Dir | tdata (low bit up)                                      | Other
// s_      | in  | character[7:0]                                          | tlast = end_of_line
// m_      | out | accepted, kind[2], channel_number[2], sensitivity_mask[8],| one word per line
//         |     | switch_on, time_valid, minutes[11], day_valid, day_code[4]|
// One character per cycle; each word is registered, then decoded in one pass into the
// token and grammar registers. A result word is registered as its tlast word is decoded.
// Reset returns the grammar and token state to idle and empties both registers.
// Only a tlast word waits on a stalled result; it holds in the input register and
// s_tready drops until the result is taken.
module heating_command_line_parser #(
    parameter int MAX_BOOST_MINUTES = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // character[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // accepted, kind, channel_number, sensitivity_mask,
                                   // switch_on, time_valid, minutes, day_valid, day_code
);

    localparam int NUM_W = $clog2(MAX_BOOST_MINUTES + 1);
    localparam int V_W   = NUM_W + 4;

    typedef struct packed {
        logic [3:0]       len;
        logic [15:0]      flags;
        logic [8:0]       dayc;
        logic [NUM_W-1:0] num;
        logic [10:0]      hm;
        logic [7:0]       smask;
    } tok_t;

    typedef struct packed {
        hcl_pkg::tk_t tk;
        logic [10:0]  val;
    } cls_t;

    typedef struct packed {
        hcl_pkg::gst_t  gst;
        hcl_pkg::held_t held;
        logic           cs;
    } gr_t;

    localparam tok_t TOK_CLR = '{len: 4'd0, flags: hcl_pkg::FL_RESET, dayc: 9'h1FF,
                                 num: '0, hm: 11'd0, smask: 8'd0};

    function automatic tok_t take(tok_t t, logic [7:0] ch);
        tok_t        r;
        logic [7:0]  lc;
        logic        isdig;
        logic [3:0]  d;
        logic [3:0]  pos;
        logic [15:0] f;
        logic [V_W-1:0] v;
        logic [10:0] hh;
        r     = t;
        pos   = t.len;
        lc    = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
        isdig = (ch >= "0" && ch <= "9");
        d     = isdig ? ch[3:0] : 4'd0;
        f     = t.flags;
        if (pos == 4'd0) begin
            if (lc != "c") f[hcl_pkg::FL_CHAN] = 1'b0;
            if (lc != "s") f[hcl_pkg::FL_SENSE] = 1'b0;
            if (isdig) begin
                f[hcl_pkg::FL_DIG] = 1'b1;
            end else begin
                f[hcl_pkg::FL_NUM]  = 1'b0;
                f[hcl_pkg::FL_TIME] = 1'b0;
            end
        end else begin
            if (pos == 4'd1 && lc == "w") begin
                f[hcl_pkg::FL_CV+:2] = 2'd0;
            end else if (pos == 4'd1 && ch >= "0" && ch <= "3") begin
                f[hcl_pkg::FL_CV+:2] = d[1:0];
            end else begin
                f[hcl_pkg::FL_CHAN] = 1'b0;
            end
            if (lc == "w") begin
                r.smask[0] = 1'b1;
            end else if (ch >= "0" && ch <= "7") begin
                r.smask = r.smask | (8'd1 << d[2:0]);
            end else begin
                f[hcl_pkg::FL_SENSE] = 1'b0;
            end
        end
        if (!isdig) begin
            f[hcl_pkg::FL_NUM] = 1'b0;
        end else if (f[hcl_pkg::FL_NUM] && !f[hcl_pkg::FL_NUM_OVER]) begin
            v = V_W'(t.num) * V_W'(10) + V_W'(d);
            if (v > V_W'(MAX_BOOST_MINUTES)) f[hcl_pkg::FL_NUM_OVER] = 1'b1;
            else r.num = v[NUM_W-1:0];
        end
        if (f[hcl_pkg::FL_TIME]) begin
            if (pos == 4'd0) begin
                r.hm = 11'(d) * 11'd10;
            end else if (pos == 4'd1 && isdig) begin
                hh = t.hm + 11'(d);
                if (hh > 11'd23) f[hcl_pkg::FL_TIME] = 1'b0;
                else r.hm = hh * 11'd60;
            end else if (pos == 4'd2 && ch == ":") begin
                r.hm = t.hm;
            end else if (pos == 4'd3 && isdig && d <= 4'd5) begin
                r.hm = t.hm + 11'(d) * 11'd10;
            end else if (pos == 4'd4 && isdig) begin
                r.hm = t.hm + 11'(d);
            end else begin
                f[hcl_pkg::FL_TIME] = 1'b0;
            end
        end
        for (int k = 0; k < hcl_pkg::NUM_KW; k++) begin
            if (!(pos < hcl_pkg::KW_LEN[k] && lc == hcl_pkg::KW_TXT[k][pos[2:0]]))
                f[hcl_pkg::FL_KW+k] = 1'b0;
        end
        for (int k = 0; k < hcl_pkg::NUM_DAYS; k++) begin
            if (!(pos < hcl_pkg::DAY_LEN[k] && lc == hcl_pkg::DAY_TXT[k][pos]))
                r.dayc[k] = 1'b0;
        end
        r.flags = f;
        r.len   = (pos < 4'd15) ? pos + 4'd1 : 4'd15;
        return r;
    endfunction

    function automatic cls_t classify(tok_t t);
        cls_t        c;
        logic        hit;
        logic [15:0] f;
        c   = '{tk: hcl_pkg::TK_OTHER, val: 11'd0};
        hit = 1'b0;
        f   = t.flags;
        if (f[hcl_pkg::FL_CHAN] && t.len == 4'd2) begin
            c = '{tk: hcl_pkg::TK_CHAN, val: 11'(f[hcl_pkg::FL_CV+:2])};
        end else if (f[hcl_pkg::FL_SENSE] && t.len >= 4'd2) begin
            c = '{tk: hcl_pkg::TK_SENSE, val: 11'(t.smask)};
        end else if (f[hcl_pkg::FL_DIG]) begin
            if (f[hcl_pkg::FL_NUM] && !f[hcl_pkg::FL_NUM_OVER])
                c = '{tk: hcl_pkg::TK_BOOST_TIME, val: 11'(t.num)};
            else if (f[hcl_pkg::FL_TIME] && t.len == 4'd5)
                c = '{tk: hcl_pkg::TK_PEG, val: t.hm};
        end else if (t.len >= 4'd2 && t.dayc != 9'd0) begin
            for (int k = hcl_pkg::NUM_DAYS - 1; k >= 0; k--) begin
                if (t.dayc[k]) c = '{tk: hcl_pkg::TK_DAY, val: 11'(k)};
            end
        end else begin
            for (int k = 0; k < hcl_pkg::NUM_KW; k++) begin
                if (!hit && f[hcl_pkg::FL_KW+k] && t.len == hcl_pkg::KW_LEN[k]) begin
                    c.tk = hcl_pkg::KW_TOK[k];
                    hit  = 1'b1;
                end
            end
        end
        return c;
    endfunction

    function automatic gr_t step(hcl_pkg::gst_t g, hcl_pkg::held_t h, cls_t c);
        gr_t r;
        r.gst  = hcl_pkg::G_ERROR;
        r.held = h;
        r.cs   = (c.tk == hcl_pkg::TK_NONE);
        case (g)
            hcl_pkg::G_IDLE: begin
                if (c.tk == hcl_pkg::TK_CHAN) begin
                    r.gst = hcl_pkg::G_CHAN; r.held.chan = c.val[1:0];
                end
            end
            hcl_pkg::G_CHAN: begin
                if (c.tk == hcl_pkg::TK_SENSE) begin
                    r.gst = hcl_pkg::G_SENSE; r.held.sense = c.val[7:0];
                end else if (c.tk == hcl_pkg::TK_BOOST) begin
                    r.gst = hcl_pkg::G_BOOST; r.held.kind = hcl_pkg::CMD_HEAT_BURST;
                end else if (c.tk == hcl_pkg::TK_DEL) begin
                    r.gst = hcl_pkg::G_DEL; r.held.kind = hcl_pkg::CMD_DEL;
                end
            end
            hcl_pkg::G_SENSE: begin
                if (c.tk == hcl_pkg::TK_ON) begin
                    r.gst = hcl_pkg::G_ONOFF; r.held.kind = hcl_pkg::CMD_ON;
                end else if (c.tk == hcl_pkg::TK_OFF) begin
                    r.gst = hcl_pkg::G_ONOFF; r.held.kind = hcl_pkg::CMD_OFF;
                end
            end
            hcl_pkg::G_BOOST: begin
                if (c.tk == hcl_pkg::TK_BOOST_TIME) begin
                    r.gst = hcl_pkg::G_DONE; r.held.minutes = c.val; r.held.tv = 1'b1;
                end else if (c.tk == hcl_pkg::TK_OFF) begin
                    r.gst = hcl_pkg::G_DONE; r.held.minutes = 11'd0; r.held.tv = 1'b1;
                end
            end
            hcl_pkg::G_DEL: begin
                if (c.tk == hcl_pkg::TK_PEG) begin
                    r.gst = hcl_pkg::G_DONE; r.held.minutes = c.val; r.held.tv = 1'b1;
                end else if (c.tk == hcl_pkg::TK_DAY) begin
                    r.gst = hcl_pkg::G_DONE; r.held.day = c.val[3:0]; r.held.dv = 1'b1;
                end
            end
            hcl_pkg::G_ONOFF: begin
                if (c.tk == hcl_pkg::TK_NOW || c.tk == hcl_pkg::TK_NONE) begin
                    r.gst = hcl_pkg::G_DONE;
                end else if (c.tk == hcl_pkg::TK_AT) begin
                    r.gst = hcl_pkg::G_AT;
                end else if (c.tk == hcl_pkg::TK_PEG) begin
                    r.gst = hcl_pkg::G_TIME; r.held.minutes = c.val; r.held.tv = 1'b1;
                end
            end
            hcl_pkg::G_AT: begin
                if (c.tk == hcl_pkg::TK_PEG) begin
                    r.gst = hcl_pkg::G_TIME; r.held.minutes = c.val; r.held.tv = 1'b1;
                end
            end
            hcl_pkg::G_TIME: begin
                if (c.tk == hcl_pkg::TK_DAY) begin
                    r.gst = hcl_pkg::G_DONE; r.held.day = c.val[3:0]; r.held.dv = 1'b1;
                end else if (c.tk == hcl_pkg::TK_NONE) begin
                    r.gst = hcl_pkg::G_DONE;
                end
            end
            hcl_pkg::G_DONE: begin
                if (c.tk == hcl_pkg::TK_NONE) r.gst = hcl_pkg::G_DONE;
            end
            default: r.gst = hcl_pkg::G_ERROR;
        endcase
        return r;
    endfunction

    logic           in_vld_reg, in_eol_reg;
    logic [7:0]     in_chr_reg;
    logic           m_vld_reg;
    logic [31:0]    m_dat_reg, m_dat_next;
    hcl_pkg::gst_t  gst_reg, gst_next;
    hcl_pkg::held_t held_reg, held_next;
    tok_t           tok_reg, tok_next;
    logic           cs_reg, cs_next;
    logic           adv;

    assign adv      = in_vld_reg && (!in_eol_reg || !m_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_dat_reg;

    always_comb begin
        logic           active, is_sp, is_nul, do_fin, do_none, acc;
        tok_t           tka;
        cls_t           cl;
        gr_t            g1, g2;
        hcl_pkg::held_t h;
        logic [1:0]     kind;
        active  = !cs_reg && gst_reg != hcl_pkg::G_ERROR;
        is_sp   = in_chr_reg == hcl_pkg::CH_SPACE;
        is_nul  = in_chr_reg == hcl_pkg::CH_NUL;
        tka     = (active && !is_sp && !is_nul) ? take(tok_reg, in_chr_reg) : tok_reg;
        do_fin  = active && (is_sp || is_nul || in_eol_reg) && tka.len != 4'd0;
        cl      = classify(tka);
        g1      = '{gst: gst_reg, held: held_reg, cs: cs_reg};
        if (do_fin) begin
            g1    = step(gst_reg, held_reg, cl);
            g1.cs = g1.cs || cs_reg;
        end
        do_none = active && (is_nul || in_eol_reg) && !g1.cs && g1.gst != hcl_pkg::G_ERROR;
        g2      = g1;
        if (do_none) begin
            g2 = step(g1.gst, g1.held, '{tk: hcl_pkg::TK_NONE, val: 11'd0});
        end
        if (active && (is_nul || in_eol_reg)) g2.cs = 1'b1;

        h    = g2.held;
        acc  = g2.gst == hcl_pkg::G_DONE && h.kind != hcl_pkg::CMD_NONE;
        kind = (h.kind == hcl_pkg::CMD_HEAT_BURST) ? hcl_pkg::KIND_BOOST :
               (h.kind == hcl_pkg::CMD_DEL) ? hcl_pkg::KIND_DEL :
               h.tv ? hcl_pkg::KIND_AT : hcl_pkg::KIND_NOW;
        m_dat_next = '0;
        if (acc) begin
            m_dat_next[0]     = 1'b1;
            m_dat_next[2:1]   = kind;
            m_dat_next[4:3]   = h.chan;
            if (h.kind == hcl_pkg::CMD_ON || h.kind == hcl_pkg::CMD_OFF) begin
                m_dat_next[12:5] = h.sense;
                m_dat_next[13]   = h.kind == hcl_pkg::CMD_ON;
            end
            m_dat_next[14]    = h.tv;
            m_dat_next[25:15] = h.tv ? h.minutes : 11'd0;
            m_dat_next[26]    = h.dv;
            m_dat_next[30:27] = h.dv ? h.day : 4'd0;
        end

        if (in_eol_reg) begin
            gst_next  = hcl_pkg::G_IDLE;
            held_next = '0;
            tok_next  = TOK_CLR;
            cs_next   = 1'b0;
        end else begin
            gst_next  = g2.gst;
            held_next = g2.held;
            tok_next  = do_fin ? TOK_CLR : tka;
            cs_next   = g2.cs;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            gst_reg    <= hcl_pkg::G_IDLE;
            held_reg   <= '0;
            tok_reg    <= TOK_CLR;
            cs_reg     <= 1'b0;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (adv && in_eol_reg) m_vld_reg <= 1'b1;
            else if (m_tready) m_vld_reg <= 1'b0;
            if (adv) begin
                gst_reg  <= gst_next;
                held_reg <= held_next;
                tok_reg  <= tok_next;
                cs_reg   <= cs_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_chr_reg <= s_tdata;
            in_eol_reg <= s_tlast;
        end
        if (adv && in_eol_reg) m_dat_reg <= m_dat_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_eol_reg |=> m_tvalid)
        else $error("line end gave no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[31:1] == 31'd0)
        else $error("rejected line carries field data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(adv && in_eol_reg) |-> gst_reg == hcl_pkg::G_IDLE && !cs_reg)
        else $error("line state not cleared after result");

endmodule

/* tb/sv/hcl_line_checker.sv */
module hcl_line_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          errors,
    output int          pending,
    output int          accepted_lines,
    output int          rejected_lines
);

    localparam int BOOST_LIMIT = 60;

    string kw_word[hcl_pkg::NUM_KW] = '{"boost", "on", "off", "now", "del", "clear", "at",
                                        "//"};
    hcl_pkg::tk_t kw_class[hcl_pkg::NUM_KW] = '{hcl_pkg::TK_BOOST, hcl_pkg::TK_ON,
                                                hcl_pkg::TK_OFF, hcl_pkg::TK_NOW,
                                                hcl_pkg::TK_DEL, hcl_pkg::TK_DEL,
                                                hcl_pkg::TK_AT, hcl_pkg::TK_NONE};
    string day_word[hcl_pkg::NUM_DAYS] = '{"today", "sunday", "monday", "tuesday",
                                           "wednesday", "thursday", "friday", "saturday",
                                           "all"};

    string field_name[9] = '{"accepted", "kind", "channel_number", "sensitivity_mask",
                             "switch_on", "time_valid", "minutes", "day_valid", "day_code"};
    int    field_lo[9]   = '{0, 1, 3, 5, 13, 14, 15, 26, 27};
    int    field_w[9]    = '{1, 2, 2, 8, 1, 1, 11, 1, 4};

    hcl_pkg::gst_t  gram;
    int             tok_len;
    logic [15:0]    cls;
    logic [8:0]     day_hits;
    int             num_acc;
    int             hhmm_acc;
    logic [7:0]     tok_mask;
    hcl_pkg::held_t cmd;
    logic           text_done;
    int             tok_val;
    logic [31:0]    line_results[$];

    task automatic reset_token();
        tok_len  = 0;
        cls      = hcl_pkg::FL_RESET;
        day_hits = '1;
        num_acc  = 0;
        hhmm_acc = 0;
        tok_mask = '0;
    endtask

    task automatic reset_line();
        gram      = hcl_pkg::G_IDLE;
        reset_token();
        cmd       = '0;
        text_done = 1'b0;
        tok_val   = 0;
    endtask

    task automatic scan_char(input logic [7:0] ch);
        int          pos;
        logic [7:0]  lc;
        logic        dig;
        int          d;
        int          v;
        logic [15:0] f;
        pos = tok_len;
        lc  = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
        dig = (ch >= "0" && ch <= "9");
        d   = dig ? int'(ch[3:0]) : 0;
        f   = cls;
        if (pos == 0) begin
            if (lc != "c") f[hcl_pkg::FL_CHAN] = 1'b0;
            if (lc != "s") f[hcl_pkg::FL_SENSE] = 1'b0;
            if (dig) f[hcl_pkg::FL_DIG] = 1'b1;
            else begin
                f[hcl_pkg::FL_NUM]  = 1'b0;
                f[hcl_pkg::FL_TIME] = 1'b0;
            end
        end else begin
            if (pos == 1 && lc == "w") f[hcl_pkg::FL_CV+:2] = 2'd0;
            else if (pos == 1 && ch >= "0" && ch <= "3") f[hcl_pkg::FL_CV+:2] = d[1:0];
            else f[hcl_pkg::FL_CHAN] = 1'b0;
            if (lc == "w") tok_mask[0] = 1'b1;
            else if (ch >= "0" && ch <= "7") tok_mask[d[2:0]] = 1'b1;
            else f[hcl_pkg::FL_SENSE] = 1'b0;
        end
        if (!dig) f[hcl_pkg::FL_NUM] = 1'b0;
        else if (f[hcl_pkg::FL_NUM] && !f[hcl_pkg::FL_NUM_OVER]) begin
            v = num_acc * 10 + d;
            if (v > BOOST_LIMIT) f[hcl_pkg::FL_NUM_OVER] = 1'b1;
            else num_acc = v;
        end
        if (f[hcl_pkg::FL_TIME]) begin
            if (pos == 0) hhmm_acc = d * 10;
            else if (pos == 1 && dig) begin
                if (hhmm_acc + d > 23) f[hcl_pkg::FL_TIME] = 1'b0;
                else hhmm_acc = (hhmm_acc + d) * 60;
            end else if (pos == 2 && ch == ":") begin
            end else if (pos == 3 && dig && d <= 5) hhmm_acc += d * 10;
            else if (pos == 4 && dig) hhmm_acc += d;
            else f[hcl_pkg::FL_TIME] = 1'b0;
        end
        for (int k = 0; k < hcl_pkg::NUM_KW; k++)
            if (pos >= kw_word[k].len() || lc != kw_word[k][pos])
                f[hcl_pkg::FL_KW + k] = 1'b0;
        for (int k = 0; k < hcl_pkg::NUM_DAYS; k++)
            if (pos >= day_word[k].len() || lc != day_word[k][pos]) day_hits[k] = 1'b0;
        cls     = f;
        tok_len = (pos < 15) ? pos + 1 : 15;
    endtask

    function automatic hcl_pkg::tk_t token_class();
        if (cls[hcl_pkg::FL_CHAN] && tok_len == 2) begin
            tok_val = int'(cls[hcl_pkg::FL_CV+:2]);
            return hcl_pkg::TK_CHAN;
        end
        if (cls[hcl_pkg::FL_SENSE] && tok_len >= 2) begin
            tok_val = int'(tok_mask);
            return hcl_pkg::TK_SENSE;
        end
        if (cls[hcl_pkg::FL_DIG]) begin
            if (cls[hcl_pkg::FL_NUM] && !cls[hcl_pkg::FL_NUM_OVER]) begin
                tok_val = num_acc;
                return hcl_pkg::TK_BOOST_TIME;
            end
            if (cls[hcl_pkg::FL_TIME] && tok_len == 5) begin
                tok_val = hhmm_acc;
                return hcl_pkg::TK_PEG;
            end
            return hcl_pkg::TK_OTHER;
        end
        if (tok_len >= 2 && day_hits != '0)
            for (int k = 0; k < hcl_pkg::NUM_DAYS; k++)
                if (day_hits[k]) begin
                    tok_val = k;
                    return hcl_pkg::TK_DAY;
                end
        for (int k = 0; k < hcl_pkg::NUM_KW; k++)
            if (cls[hcl_pkg::FL_KW + k] && tok_len == kw_word[k].len()) return kw_class[k];
        return hcl_pkg::TK_OTHER;
    endfunction

    task automatic advance_grammar(input hcl_pkg::tk_t tk);
        hcl_pkg::gst_t nx;
        nx = hcl_pkg::G_ERROR;
        case (gram)
            hcl_pkg::G_IDLE: if (tk == hcl_pkg::TK_CHAN) begin
                nx = hcl_pkg::G_CHAN;
                cmd.chan = tok_val[1:0];
            end
            hcl_pkg::G_CHAN: if (tk == hcl_pkg::TK_SENSE) begin
                nx = hcl_pkg::G_SENSE;
                cmd.sense = tok_val[7:0];
            end else if (tk == hcl_pkg::TK_BOOST) begin
                nx = hcl_pkg::G_BOOST;
                cmd.kind = hcl_pkg::CMD_HEAT_BURST;
            end else if (tk == hcl_pkg::TK_DEL) begin
                nx = hcl_pkg::G_DEL;
                cmd.kind = hcl_pkg::CMD_DEL;
            end
            hcl_pkg::G_SENSE: if (tk == hcl_pkg::TK_ON) begin
                nx = hcl_pkg::G_ONOFF;
                cmd.kind = hcl_pkg::CMD_ON;
            end else if (tk == hcl_pkg::TK_OFF) begin
                nx = hcl_pkg::G_ONOFF;
                cmd.kind = hcl_pkg::CMD_OFF;
            end
            hcl_pkg::G_BOOST: if (tk == hcl_pkg::TK_BOOST_TIME) begin
                nx = hcl_pkg::G_DONE;
                cmd.minutes = tok_val[10:0];
                cmd.tv = 1'b1;
            end else if (tk == hcl_pkg::TK_OFF) begin
                nx = hcl_pkg::G_DONE;
                cmd.minutes = '0;
                cmd.tv = 1'b1;
            end
            hcl_pkg::G_DEL: if (tk == hcl_pkg::TK_PEG) begin
                nx = hcl_pkg::G_DONE;
                cmd.minutes = tok_val[10:0];
                cmd.tv = 1'b1;
            end else if (tk == hcl_pkg::TK_DAY) begin
                nx = hcl_pkg::G_DONE;
                cmd.day = tok_val[3:0];
                cmd.dv = 1'b1;
            end
            hcl_pkg::G_ONOFF: if (tk == hcl_pkg::TK_NOW || tk == hcl_pkg::TK_NONE) begin
                nx = hcl_pkg::G_DONE;
            end else if (tk == hcl_pkg::TK_AT) begin
                nx = hcl_pkg::G_AT;
            end else if (tk == hcl_pkg::TK_PEG) begin
                nx = hcl_pkg::G_TIME;
                cmd.minutes = tok_val[10:0];
                cmd.tv = 1'b1;
            end
            hcl_pkg::G_AT: if (tk == hcl_pkg::TK_PEG) begin
                nx = hcl_pkg::G_TIME;
                cmd.minutes = tok_val[10:0];
                cmd.tv = 1'b1;
            end
            hcl_pkg::G_TIME: if (tk == hcl_pkg::TK_DAY) begin
                nx = hcl_pkg::G_DONE;
                cmd.day = tok_val[3:0];
                cmd.dv = 1'b1;
            end else if (tk == hcl_pkg::TK_NONE) begin
                nx = hcl_pkg::G_DONE;
            end
            hcl_pkg::G_DONE: if (tk == hcl_pkg::TK_NONE) nx = hcl_pkg::G_DONE;
            default: ;
        endcase
        gram = nx;
        if (tk == hcl_pkg::TK_NONE) text_done = 1'b1;
    endtask

    task automatic close_token();
        if (tok_len > 0) begin
            tok_val = 0;
            advance_grammar(token_class());
            reset_token();
        end
    endtask

    task automatic close_text();
        close_token();
        if (!text_done && gram != hcl_pkg::G_ERROR) begin
            tok_val = 0;
            advance_grammar(hcl_pkg::TK_NONE);
        end
        text_done = 1'b1;
    endtask

    task automatic parse_word(input logic [7:0] ch, input logic eol);
        logic [31:0] r;
        if (!text_done && gram != hcl_pkg::G_ERROR) begin
            if (ch == hcl_pkg::CH_SPACE) close_token();
            else if (ch == hcl_pkg::CH_NUL) close_text();
            else scan_char(ch);
        end
        if (eol) begin
            if (!text_done && gram != hcl_pkg::G_ERROR) close_text();
            r = '0;
            if (gram == hcl_pkg::G_DONE && cmd.kind != hcl_pkg::CMD_NONE) begin
                r[0]   = 1'b1;
                r[4:3] = cmd.chan;
                if (cmd.kind == hcl_pkg::CMD_ON || cmd.kind == hcl_pkg::CMD_OFF) begin
                    r[2:1]  = cmd.tv ? hcl_pkg::KIND_AT : hcl_pkg::KIND_NOW;
                    r[12:5] = cmd.sense;
                    r[13]   = (cmd.kind == hcl_pkg::CMD_ON);
                end else begin
                    r[2:1] = (cmd.kind == hcl_pkg::CMD_HEAT_BURST) ? hcl_pkg::KIND_BOOST :
                                                                     hcl_pkg::KIND_DEL;
                end
                r[14]    = cmd.tv;
                r[25:15] = cmd.tv ? cmd.minutes : 11'd0;
                r[26]    = cmd.dv;
                r[30:27] = cmd.dv ? cmd.day : 4'd0;
            end
            line_results.push_back(r);
            reset_line();
        end
    endtask

    task automatic compare_result(input logic [31:0] got);
        logic [31:0] want;
        logic [31:0] msk;
        if (line_results.size() == 0) begin
            $error("result word 0x%08h arrived with nothing expected", got);
            errors++;
        end else begin
            want = line_results.pop_front();
            if (got[0]) accepted_lines++;
            else rejected_lines++;
            for (int i = 0; i < 9; i++) begin
                msk = (32'd1 << field_w[i]) - 32'd1;
                if (((want >> field_lo[i]) & msk) != ((got >> field_lo[i]) & msk)) begin
                    $error("%s: expected %0d, got %0d", field_name[i],
                           (want >> field_lo[i]) & msk, (got >> field_lo[i]) & msk);
                    errors++;
                end
            end
            if (got[31]) begin
                $error("pad: expected 0, got 1");
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_line();
            line_results.delete();
        end else begin
            if (m_tvalid && m_tready) compare_result(m_tdata);
            if (s_tvalid && s_tready) parse_word(s_tdata, s_tlast);
        end
        pending = line_results.size();
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;

    localparam int LIMIT      = 300000;
    localparam int HOLD_SPAN  = 400;
    localparam int CHAR_GOAL  = 650;
    localparam int LINE_GOAL  = 42;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int errors, pending, accepted_lines, rejected_lines;

    logic [8:0] tx_words[$];
    logic [7:0] line_buf[$];
    int         burst_left = 0;
    int         gap_left = 0;
    logic       steady = 1'b0;
    logic       hold_kick = 1'b0;
    int         hold_left = 0;
    int         stall_pct = 20;
    int         cycles = 0;
    int         chars_sent = 0;
    int         lines_sent = 0;

    string day_word[hcl_pkg::NUM_DAYS] = '{"today", "sunday", "monday", "tuesday",
                                           "wednesday", "thursday", "friday", "saturday",
                                           "all"};

    heating_command_line_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    hcl_line_checker line_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending),
        .accepted_lines(accepted_lines), .rejected_lines(rejected_lines)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        logic [8:0] w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (tx_words.size() > 0) begin
                w = tx_words.pop_front();
                s_tdata  <= w[7:0];
                s_tlast  <= w[8];
                s_tvalid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = steady ? 0 : $urandom_range(0, 5);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = HOLD_SPAN;
            m_tready <= 1'b0;
        end else begin
            if (cycles % 97 == 0) stall_pct = $urandom_range(0, 3) * 20;
            m_tready <= steady || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic add_text(string s);
        logic [7:0] c;
        foreach (s[i]) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 11) == 0) c = c - 8'd32;
            line_buf.push_back(c);
        end
    endtask

    task automatic add_gap();
        line_buf.push_back(hcl_pkg::CH_SPACE);
        if ($urandom_range(0, 9) == 0) line_buf.push_back(hcl_pkg::CH_SPACE);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) tx_words.push_back({i == line_buf.size() - 1, line_buf[i]});
        chars_sent += line_buf.size();
        lines_sent++;
        line_buf.delete();
    endtask

    task automatic send_text(string s);
        add_text(s);
        send_line();
    endtask

    function automatic string chan_tok();
        case ($urandom_range(0, 11))
            0: return "c4";
            1: return "c";
            2: return "cw";
            default: return $sformatf("c%0d", $urandom_range(0, 3));
        endcase
    endfunction

    function automatic string sense_tok();
        string s, digs;
        digs = "01234567w";
        s = "s";
        if ($urandom_range(0, 11) == 0) return "s9";
        repeat ($urandom_range(1, 4)) s = {s, string'(digs[$urandom_range(0, 8)])};
        return s;
    endfunction

    function automatic string time_tok();
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1)) return $sformatf("%0d:%02d", $urandom_range(0, 9),
                                                      $urandom_range(0, 59));
            return $sformatf("%02d:%02d", $urandom_range(20, 29), $urandom_range(50, 69));
        end
        return $sformatf("%02d:%02d", $urandom_range(0, 23), $urandom_range(0, 59));
    endfunction

    function automatic string day_tok();
        string d;
        if ($urandom_range(0, 9) == 0) return "xy";
        d = day_word[$urandom_range(0, hcl_pkg::NUM_DAYS - 1)];
        return d.substr(0, $urandom_range(1, d.len() - 1));
    endfunction

    function automatic string boost_tok();
        case ($urandom_range(0, 7))
            0: return $sformatf("%0d", $urandom_range(61, 9999));
            1: return $sformatf("00%0d", $urandom_range(0, 60));
            2: return "123456789012345678";
            3: return "off";
            default: return $sformatf("%0d", $urandom_range(0, 60));
        endcase
    endfunction

    task automatic random_line();
        int shape;
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
            send_line();
            return;
        end
        if ($urandom_range(0, 15) == 0) line_buf.push_back(hcl_pkg::CH_SPACE);
        add_text(chan_tok());
        add_gap();
        case ($urandom_range(0, 3))
            0: begin
                add_text(sense_tok());
                add_gap();
                add_text($urandom_range(0, 1) ? string'("on") : string'("off"));
                if ($urandom_range(0, 1)) begin
                    add_gap();
                    add_text("now");
                end
            end
            1: begin
                add_text(sense_tok());
                add_gap();
                add_text($urandom_range(0, 1) ? string'("on") : string'("off"));
                add_gap();
                if ($urandom_range(0, 1)) begin
                    add_text("at");
                    add_gap();
                end
                add_text(time_tok());
                if ($urandom_range(0, 1)) begin
                    add_gap();
                    add_text(day_tok());
                end
            end
            2: begin
                add_text("boost");
                add_gap();
                add_text(boost_tok());
            end
            default: begin
                add_text($urandom_range(0, 1) ? string'("del") : string'("clear"));
                add_gap();
                add_text($urandom_range(0, 1) ? time_tok() : day_tok());
            end
        endcase
        case ($urandom_range(0, 9))
            0: add_text(" // junk");
            1: begin
                line_buf.push_back(hcl_pkg::CH_NUL);
                add_text("zz");
            end
            2: line_buf.push_back(hcl_pkg::CH_SPACE);
            3: add_text(" now");
            default: ;
        endcase
        send_line();
    endtask

    task automatic wait_drained();
        while (tx_words.size() > 0 || s_tvalid || pending > 0) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_text("c0 s01234567 on");
        send_text("cw sw off now");
        send_text("c3 s7 on at 23:59 saturday");
        send_text("c1 s0 on 00:00 today");
        send_text("C2 S3 OFF AT 09:05 FR");
        send_text("c2 boost 60");
        send_text("c2 boost 61");
        send_text("c0 boost off");
        send_text("c1 del 12:30");
        send_text("c1 clear all");
        send_text("c3 del we");
        send_text("c0 s1 on 24:00");
        send_text("c0 s1 on 12:60");
        send_text("c1 s2 on now // c9");
        send_text("c0 boost 00000000000000060");
        send_text("c0 s1 on ");
        line_buf.push_back(8'hFF);
        line_buf.push_back(hcl_pkg::CH_NUL);
        send_line();
        wait_drained();

        while (chars_sent < CHAR_GOAL || lines_sent < LINE_GOAL) begin
            while (tx_words.size() > 48) @(posedge aclk);
            if (lines_sent == 24) hold_kick = 1'b1;
            if (lines_sent == 32) wait_drained();
            steady = (lines_sent >= 36 && lines_sent < 42);
            random_line();
        end
        steady = 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Sent %0d lines (%0d characters) over directed and random commands,",
                 lines_sent, chars_sent);
        $display("with %0d accepted and %0d rejected results, a long result stall and a drain.",
                 accepted_lines, rejected_lines);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
